### src/assert_macros.svh
// Assertion macros used by the checker of the tridiagonal solver.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on the rising clock edge, quiet while reset is asserted.
`define TTS_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent check that a condition never holds.
`define TTS_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  `TTS_ASSERT(lbl, clk, rst_n, !(cond), msg)

`endif

### src/tts_pkg.sv
// Shared types, constants and fixed-point helpers of the tridiagonal solver.
package tts_pkg;

  localparam int QW           = 48;
  localparam int MAX_UNKNOWNS = 64;
  localparam int IDX_W        = $clog2(MAX_UNKNOWNS);
  localparam int CFG_IDX_W    = 2;

  localparam logic signed [QW-1:0] Q_MAX = {1'b0, {(QW-1){1'b1}}};
  localparam logic signed [QW-1:0] Q_MIN = {1'b1, {(QW-1){1'b0}}};
  localparam logic signed [QW-1:0] Q_ONE = 48'sh0001_0000_0000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SUB   = 2'd0,
    CFG_DIAG  = 2'd1,
    CFG_SUPER = 2'd2
  } cfg_idx_e;

  typedef enum logic [3:0] {
    S_IDLE, S_MUL1, S_MUL2, S_DIV, S_DIVW, S_WRITE, S_EMIT, S_RD, S_BMUL
  } back_state_e;

  typedef enum logic [1:0] {
    DV_IDLE, DV_CHK, DV_RUN, DV_FIN
  } div_state_e;

  typedef struct packed {
    logic signed [QW-1:0] value;
    logic                 last;
  } rhs_req_t;

  typedef struct packed {
    logic signed [QW-1:0] value;
    logic [IDX_W-1:0]     index;
    logic                 last;
    logic                 err;
  } sol_res_t;

  // Magnitude of a signed value; the most negative value maps to 2^47.
  function automatic logic [QW-1:0] mag_of(input logic signed [QW-1:0] v);
    return v[QW-1] ? QW'(-v) : QW'(v);
  endfunction

  // Apply a sign to a magnitude, saturating at the Q16.32 limits.
  function automatic logic signed [QW-1:0] from_mag(input logic neg,
                                                    input logic [64:0] mag);
    logic big;
    big = (mag >= {17'b0, Q_MIN});
    if (big) return neg ? Q_MIN : Q_MAX;
    return neg ? -$signed(mag[QW-1:0]) : $signed(mag[QW-1:0]);
  endfunction

  // Saturating difference a - b.
  function automatic logic signed [QW-1:0] sat_sub(input logic signed [QW-1:0] a,
                                                   input logic signed [QW-1:0] b);
    logic signed [QW:0] d;
    d = {a[QW-1], a} - {b[QW-1], b};
    if (d[QW] != d[QW-1]) return d[QW] ? Q_MIN : Q_MAX;
    return d[QW-1:0];
  endfunction

endpackage

### src/tts_front.sv
// Input queue that takes right-hand-side requests and holds them for the sweep engine.
module tts_front import tts_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  rhs_req_t in_req_i,
  output logic     req_valid_o,
  input  logic     req_pop_i,
  output rhs_req_t req_o
);

  rhs_req_t   buf_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  logic       push, pop;

  assign in_ready_o  = (cnt_q != 2'd2);
  assign req_valid_o = (cnt_q != 2'd0);
  assign req_o       = buf_q[rd_q];
  assign push        = in_valid_i & in_ready_o;
  assign pop         = req_pop_i & req_valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wr_q <= ~wr_q;
      if (pop)  rd_q <= ~rd_q;
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) buf_q[wr_q] <= in_req_i;
  end

endmodule

### src/tts_mul.sv
// Iterative Q16.32 multiplier built from four 24 by 24 bit partial products.
module tts_mul import tts_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic signed [QW-1:0] a_i,
  input  logic signed [QW-1:0] b_i,
  output logic                 done_o,
  output logic signed [QW-1:0] res_o
);

  localparam int HW = QW / 2;

  logic              busy_q, done_q, neg_q;
  logic [2:0]        cnt_q;
  logic [QW-1:0]     ma_q, mb_q;
  logic [2*QW-1:0]   acc_q, pp_sh;
  logic [HW-1:0]     a_sel, b_sel;
  logic [QW-1:0]     pp;
  logic [65:0]       rsum;
  logic signed [QW-1:0] res_q;

  assign a_sel = cnt_q[1] ? ma_q[QW-1:HW] : ma_q[HW-1:0];
  assign b_sel = cnt_q[0] ? mb_q[QW-1:HW] : mb_q[HW-1:0];
  assign pp    = a_sel * b_sel;

  always_comb begin
    unique case (cnt_q[1:0])
      2'd0:    pp_sh = {{QW{1'b0}}, pp};
      2'd3:    pp_sh = {pp, {QW{1'b0}}};
      default: pp_sh = {{HW{1'b0}}, pp, {HW{1'b0}}};
    endcase
  end

  // Round to nearest with ties away from zero: add half an LSB of Q16.32.
  assign rsum = {1'b0, acc_q[2*QW-1:31]} + 66'd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= 3'd0;
    end else begin
      done_q <= 1'b0;
      if (start_i && !busy_q) begin
        busy_q <= 1'b1;
        cnt_q  <= 3'd0;
      end else if (busy_q) begin
        if (cnt_q == 3'd4) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q + 3'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && !busy_q) begin
      neg_q <= a_i[QW-1] ^ b_i[QW-1];
      ma_q  <= mag_of(a_i);
      mb_q  <= mag_of(b_i);
      acc_q <= '0;
    end else if (busy_q) begin
      if (cnt_q == 3'd4) res_q <= from_mag(neg_q, rsum[65:1]);
      else               acc_q <= acc_q + pp_sh;
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

### src/tts_div.sv
// Restoring Q16.32 divider that resolves one quotient bit per cycle.
module tts_div import tts_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic signed [QW-1:0] num_i,
  input  logic signed [QW-1:0] den_i,
  output logic                 done_o,
  output logic signed [QW-1:0] quo_o
);

  div_state_e           state_q, state_d;
  logic                 neg_q, done_q, ovf, ge, rnd;
  logic [QW-1:0]        n_q, d_q, q_q;
  logic [QW:0]          r_q, t, qr;
  logic [IDX_W-1:0]     cnt_q;
  logic signed [QW-1:0] quo_q;

  // The integer part must stay below 2^16 or the quotient saturates.
  assign ovf = ({16'b0, n_q} >= {d_q, 16'b0});
  assign t   = {r_q[QW-1:0], n_q[QW-1]};
  assign ge  = (t >= {1'b0, d_q});
  assign rnd = ({r_q, 1'b0} >= {2'b0, d_q});
  assign qr  = {1'b0, q_q} + (QW+1)'(rnd);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      DV_IDLE: if (start_i) state_d = DV_CHK;
      DV_CHK:  state_d = ovf ? DV_IDLE : DV_RUN;
      DV_RUN:  if (cnt_q == '0) state_d = DV_FIN;
      DV_FIN:  state_d = DV_IDLE;
      default: state_d = DV_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= DV_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == DV_FIN) || (state_q == DV_CHK && ovf);
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      DV_IDLE: if (start_i) begin
        neg_q <= num_i[QW-1] ^ den_i[QW-1];
        n_q   <= mag_of(num_i);
        d_q   <= mag_of(den_i);
      end
      DV_CHK: begin
        if (ovf) begin
          quo_q <= neg_q ? Q_MIN : Q_MAX;
        end else begin
          r_q   <= {17'b0, n_q[QW-1:16]};
          n_q   <= {n_q[15:0], 32'b0};
          q_q   <= '0;
          cnt_q <= IDX_W'(QW - 1);
        end
      end
      DV_RUN: begin
        r_q   <= ge ? (t - {1'b0, d_q}) : t;
        q_q   <= {q_q[QW-2:0], ge};
        n_q   <= {n_q[QW-2:0], 1'b0};
        cnt_q <= cnt_q - 1'b1;
      end
      DV_FIN: quo_q <= from_mag(neg_q, 65'(qr));
      default: ;
    endcase
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

### src/tts_back.sv
// Sweep engine: forward elimination per request, then back substitution and result output.
module tts_back import tts_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 req_valid_i,
  input  rhs_req_t             req_i,
  output logic                 req_pop_o,
  input  logic signed [QW-1:0] sub_i,
  input  logic signed [QW-1:0] diag_i,
  input  logic signed [QW-1:0] super_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output sol_res_t             out_o
);

  back_state_e state_q, state_d;

  logic signed [QW-1:0] ms_mem [MAX_UNKNOWNS];
  logic signed [QW-1:0] ps_mem [MAX_UNKNOWNS];

  logic [IDX_W-1:0]     k_q, j_q;
  logic                 last_q, zp_q, ms_ok_q, ps_ok_q, out_valid_q;
  logic signed [QW-1:0] rhs_q, pivot_q, num_q, prev_ms_q, prev_ps_q;
  logic signed [QW-1:0] new_ms_q, new_ps_q, x_q, ms_rd_q, ps_rd_q;
  sol_res_t             out_q;

  logic                 mul_start, mul_done, div_start, ms_done, ps_done;
  logic                 emit_go, rd_en;
  logic signed [QW-1:0] mul_a, mul_b, mul_res, ms_quo, ps_quo;

  assign mul_a = (state_q == S_RD) ? ms_rd_q : sub_i;
  always_comb begin
    unique case (state_q)
      S_IDLE:  mul_b = prev_ms_q;
      S_MUL1:  mul_b = prev_ps_q;
      default: mul_b = x_q;
    endcase
  end

  tts_mul u_mul (
    .clk_i, .rst_ni, .start_i(mul_start), .a_i(mul_a), .b_i(mul_b),
    .done_o(mul_done), .res_o(mul_res)
  );

  tts_div u_div_ms (
    .clk_i, .rst_ni, .start_i(div_start), .num_i(super_i), .den_i(pivot_q),
    .done_o(ms_done), .quo_o(ms_quo)
  );

  tts_div u_div_ps (
    .clk_i, .rst_ni, .start_i(div_start), .num_i(num_q), .den_i(pivot_q),
    .done_o(ps_done), .quo_o(ps_quo)
  );

  assign emit_go = !out_valid_q || out_ready_i;

  always_comb begin
    state_d   = state_q;
    req_pop_o = 1'b0;
    mul_start = 1'b0;
    div_start = 1'b0;
    rd_en     = 1'b0;
    unique case (state_q)
      S_IDLE: if (req_valid_i) begin
        req_pop_o = 1'b1;
        if (k_q == '0) begin
          state_d = S_DIV;
        end else begin
          mul_start = 1'b1;
          state_d   = S_MUL1;
        end
      end
      S_MUL1: if (mul_done) begin
        mul_start = 1'b1;
        state_d   = S_MUL2;
      end
      S_MUL2: if (mul_done) state_d = S_DIV;
      S_DIV: begin
        if (pivot_q == '0) begin
          state_d = S_WRITE;
        end else begin
          div_start = 1'b1;
          state_d   = S_DIVW;
        end
      end
      S_DIVW: if (ms_ok_q && ps_ok_q) state_d = S_WRITE;
      S_WRITE: begin
        if (last_q || k_q == IDX_W'(MAX_UNKNOWNS - 1)) state_d = S_EMIT;
        else                                          state_d = S_IDLE;
      end
      S_EMIT: if (emit_go) begin
        if (j_q == '0) begin
          state_d = S_IDLE;
        end else begin
          rd_en   = 1'b1;
          state_d = S_RD;
        end
      end
      S_RD: begin
        mul_start = 1'b1;
        state_d   = S_BMUL;
      end
      S_BMUL: if (mul_done) state_d = S_EMIT;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      k_q         <= '0;
      zp_q        <= 1'b0;
      out_valid_q <= 1'b0;
      ms_ok_q     <= 1'b0;
      ps_ok_q     <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_EMIT && emit_go) out_valid_q <= 1'b1;
      else if (out_ready_i)             out_valid_q <= 1'b0;
      if (state_q == S_DIV) begin
        ms_ok_q <= 1'b0;
        ps_ok_q <= 1'b0;
        if (pivot_q == '0) zp_q <= 1'b1;
      end
      if (ms_done) ms_ok_q <= 1'b1;
      if (ps_done) ps_ok_q <= 1'b1;
      if (state_q == S_WRITE && state_d == S_IDLE) k_q <= k_q + 1'b1;
      if (state_q == S_EMIT && emit_go) begin
        if (j_q == '0) begin
          k_q  <= '0;
          zp_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: if (req_valid_i) begin
        rhs_q  <= req_i.value;
        last_q <= req_i.last;
        if (k_q == '0) begin
          pivot_q <= diag_i;
          num_q   <= req_i.value;
        end
      end
      S_MUL1: if (mul_done) pivot_q <= sat_sub(diag_i, mul_res);
      S_MUL2: if (mul_done) num_q <= sat_sub(rhs_q, mul_res);
      S_DIV: if (pivot_q == '0) begin
        new_ms_q <= '0;
        new_ps_q <= '0;
      end
      S_WRITE: begin
        ms_mem[k_q] <= new_ms_q;
        ps_mem[k_q] <= new_ps_q;
        prev_ms_q   <= new_ms_q;
        prev_ps_q   <= new_ps_q;
        x_q         <= new_ps_q;
        j_q         <= k_q;
      end
      S_EMIT: if (emit_go) begin
        out_q.value <= zp_q ? '0 : x_q;
        out_q.index <= j_q;
        out_q.last  <= (j_q == '0);
        out_q.err   <= zp_q;
        if (j_q != '0) j_q <= j_q - 1'b1;
      end
      S_BMUL: if (mul_done) x_q <= sat_sub(ps_rd_q, mul_res);
      default: ;
    endcase
    if (ms_done) new_ms_q <= ms_quo;
    if (ps_done) new_ps_q <= ps_quo;
    if (rd_en) begin
      ms_rd_q <= ms_mem[j_q - 1'b1];
      ps_rd_q <= ps_mem[j_q - 1'b1];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

### src/tridiagonal_thomas_solver.sv
// Tridiagonal solver by the Thomas algorithm with constant sub, main and super
// diagonal coefficients held in three configuration registers (index 0 sub,
// 1 main, 2 super; signed Q16.32, the main diagonal resets to one). Each
// request on the slave stream carries one right-hand-side element in ascending
// row order; tlast closes the system, and the 64th row closes it as well. The
// forward sweep runs while the elements arrive: a row takes two multiplies and
// then the two divisions of the row, which run side by side on two bit-serial
// dividers that resolve one quotient bit per cycle (row zero skips the
// multiplies, a zero pivot skips the division). After the last element the
// solution leaves on the master stream from the highest index down to zero,
// each element below the highest after the memory read and the multiply of
// the back substitution. A two-entry queue at the input keeps taking requests
// while the engine is busy, until it is full, and an output register holds a
// finished result until it is taken. All arithmetic rounds to nearest, ties
// away from zero, and saturates; a zero pivot forces every result of that
// system to zero with the error flag in tuser set. Coefficients must only
// change while idle.
module tridiagonal_thomas_solver import tts_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [47:0]          s_axis_tdata,  // rhs_value[47:0]
  input  logic                 s_axis_tlast,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [55:0]          m_axis_tdata,  // solution_value[47:0], solution_index[53:48], zero pad
  output logic                 m_axis_tlast,
  output logic                 m_axis_tuser,  // pivot_error
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [QW-1:0]        cfg_data_i
);

  logic signed [QW-1:0] sub_q, diag_q, super_q;
  rhs_req_t             in_req, req;
  logic                 req_valid, req_pop;
  sol_res_t             res;

  // Coefficient registers; indexes beyond the list are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sub_q   <= '0;
      diag_q  <= Q_ONE;
      super_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_SUB:   sub_q   <= cfg_data_i;
        CFG_DIAG:  diag_q  <= cfg_data_i;
        CFG_SUPER: super_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign in_req.value = s_axis_tdata;
  assign in_req.last  = s_axis_tlast;

  tts_front u_front (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready), .in_req_i(in_req),
    .req_valid_o(req_valid), .req_pop_i(req_pop), .req_o(req)
  );

  tts_back u_back (
    .clk_i, .rst_ni,
    .req_valid_i(req_valid), .req_i(req), .req_pop_o(req_pop),
    .sub_i(sub_q), .diag_i(diag_q), .super_i(super_q),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready), .out_o(res)
  );

  assign m_axis_tdata = {2'b00, res.index, res.value};
  assign m_axis_tlast = res.last;
  assign m_axis_tuser = res.err;

endmodule

### src/tts_checker.sv
// Port-level checker of the tridiagonal solver and its bind to the top level.
`include "assert_macros.svh"

module tts_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [55:0] m_axis_tdata,
  input logic        m_axis_tlast,
  input logic        m_axis_tuser
);

  `TTS_ASSERT(a_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")
  `TTS_ASSERT(a_last_idx, clk_i, rst_ni, m_axis_tvalid |-> (m_axis_tlast == (m_axis_tdata[53:48] == 6'd0)), "tlast does not match index zero")
  `TTS_ASSERT(a_err_zero, clk_i, rst_ni, m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[47:0] == 48'd0, "pivot error with nonzero value")
  `TTS_ASSERT_NEVER(a_pad, clk_i, rst_ni, m_axis_tvalid && m_axis_tdata[55:54] != 2'b00, "padding bits set")

endmodule

bind tridiagonal_thomas_solver tts_checker u_tts_checker (
  .clk_i(clk_i), .rst_ni(rst_ni),
  .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
  .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast), .m_axis_tuser(m_axis_tuser)
);
